### sv/sipq_pkg.sv
package sipq_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RD_N     = (CAPACITY < (1 << IDX_W)) ? CAPACITY : (1 << IDX_W);
  localparam int CMPW     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam logic  KindAdd  = 1'b0;
  localparam logic  KindRead = 1'b1;
  localparam data_t NegOne   = -32'sd1;

  // Control that the top level hands to each cell of the chain.
  typedef struct packed {
    logic cmp_en;      // a request is accepted: capture the compare flag
    logic upd_en;      // an add is committed this cycle and the queue is not full
    logic valid;       // the cell holds a stored entry
    logic at_end;      // the cell is the first free place
    logic last;        // the cell holds the back entry
    logic tail_ovr;    // the back test placed the value at the end
    logic descending;
  } cell_ctl_t;

  // True when a belongs at or before b under the current order.
  function automatic logic goes_before(data_t a, data_t b, logic desc);
    goes_before = desc ? (a >= b) : (a <= b);
  endfunction

endpackage

### sv/sipq_cell.sv
module sipq_cell (
  input  logic                clk_i,
  input  sipq_pkg::cell_ctl_t ctl_i,
  input  sipq_pkg::data_t     cmp_value_i,
  input  sipq_pkg::data_t     ins_value_i,
  input  sipq_pkg::data_t     prev_entry_i,
  input  logic                found_i,
  output logic                found_o,
  output logic                hit_o,
  output logic                tail_o,
  output sipq_pkg::data_t     entry_o
);
  import sipq_pkg::*;

  data_t entry_q, entry_d;
  logic  hit_q;
  logic  here;

  assign hit_o  = ctl_i.valid && goes_before(cmp_value_i, entry_q, ctl_i.descending);
  assign tail_o = ctl_i.last && goes_before(entry_q, cmp_value_i, ctl_i.descending);

  // The insertion place is the first cell that claims it; every cell behind it
  // up to the first free place takes its left neighbour's entry.
  assign here    = !found_i && ((hit_q && !ctl_i.tail_ovr) || ctl_i.at_end);
  assign found_o = found_i || here;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.upd_en) begin
      if (here) begin
        entry_d = ins_value_i;
      end else if (found_i && (ctl_i.valid || ctl_i.at_end)) begin
        entry_d = prev_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctl_i.cmp_en) begin
      hit_q <= hit_o;
    end
  end

  assign entry_o = entry_q;

endmodule

### sv/sorted_insert_priority_queue.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-----------------------------------
// in       | input     | in_valid_i / in_stall_o | kind_i, value_i, index_i
// out      | output    | out_valid_o/ out_stall_i| read_value_o, read_ok_o, count_o,
//          |           |                         | dropped_o
// cfg      | input     | cfg_valid_i/ cfg_ready_o| cfg_descending_i
//
// Each request passes through the states StIdle and StUpd: on acceptance in StIdle every
// cell compares the new value with its entry, and in StUpd the insertion place ripples
// along the chain, the chain shifts and the result is registered. A new request is not
// accepted until the one before it has committed its result.
// Reset clears the count, the order register and the output valid; entries are left
// as they are and are never read before they are written. A stalled output holds its
// result, and a request accepted behind it waits in its update cycle until it is free.
module sorted_insert_priority_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  sipq_pkg::data_t       value_i,
  input  logic [3:0]            index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sipq_pkg::data_t       read_value_o,
  output logic                  read_ok_o,
  output logic [4:0]            count_o,
  output logic                  dropped_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_descending_i
);
  import sipq_pkg::*;

  typedef enum logic {StIdle, StUpd} state_e;

  state_e state_q;
  logic   out_valid_q;
  data_t  rv_q;
  logic   ok_q;
  cnt_t   count_q;
  logic [COUNT_W-1:0] cnt_res_q;
  logic   drop_q;
  logic   descending_q;

  // Request held for the update cycle.
  logic             kind_q;
  data_t            val_q;
  logic [IDX_W-1:0] index_q;
  logic             tail_ovr_q;

  logic in_acc, out_free, commit, full, upd_en;

  cell_ctl_t           cell_ctl [CAPACITY];
  data_t               entries  [CAPACITY];
  logic [CAPACITY-1:0] found_w;
  logic [CAPACITY-1:0] tail_w;
  logic                hit0;

  data_t rd_value;
  logic  rd_ok;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign commit      = (state_q == StUpd) && out_free;
  assign full        = (count_q == CNT_W'(CAPACITY));
  assign upd_en      = commit && (kind_q == KindAdd) && !full;
  assign cfg_ready_o = 1'b1;

  // The front cell claims nothing ahead of it.
  assign found_w[0] = 1'b0;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    assign cell_ctl[gi] = '{
      cmp_en:     in_acc,
      upd_en:     upd_en,
      valid:      (CNT_W'(gi) < count_q),
      at_end:     (count_q == CNT_W'(gi)),
      last:       (count_q == CNT_W'(gi + 1)),
      tail_ovr:   tail_ovr_q,
      descending: descending_q
    };

    if (gi == 0) begin : g_front
      sipq_cell u_cell (
        .clk_i        (clk_i),
        .ctl_i        (cell_ctl[gi]),
        .cmp_value_i  (value_i),
        .ins_value_i  (val_q),
        .prev_entry_i (val_q),
        .found_i      (found_w[gi]),
        .found_o      (found_w[gi+1]),
        .hit_o        (hit0),
        .tail_o       (tail_w[gi]),
        .entry_o      (entries[gi])
      );
    end else if (gi < CAPACITY - 1) begin : g_mid
      sipq_cell u_cell (
        .clk_i        (clk_i),
        .ctl_i        (cell_ctl[gi]),
        .cmp_value_i  (value_i),
        .ins_value_i  (val_q),
        .prev_entry_i (entries[gi-1]),
        .found_i      (found_w[gi]),
        .found_o      (found_w[gi+1]),
        .hit_o        (),
        .tail_o       (tail_w[gi]),
        .entry_o      (entries[gi])
      );
    end else begin : g_back
      sipq_cell u_cell (
        .clk_i        (clk_i),
        .ctl_i        (cell_ctl[gi]),
        .cmp_value_i  (value_i),
        .ins_value_i  (val_q),
        .prev_entry_i (entries[gi-1]),
        .found_i      (found_w[gi]),
        .found_o      (),
        .hit_o        (),
        .tail_o       (tail_w[gi]),
        .entry_o      (entries[gi])
      );
    end
  end

  // Read path: the index reaches at most the first sixteen cells.
  always_comb begin
    rd_value = NegOne;
    for (int k = 0; k < RD_N; k++) begin
      if (index_q == IDX_W'(k)) begin
        rd_value = entries[k];
      end
    end
    rd_ok = (CMPW'(index_q) < CMPW'(count_q));
  end

  // Request registers. When the front test fails but the back test passes,
  // the value goes to the end whatever the cells in between say.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q     <= kind_i;
      val_q      <= value_i;
      index_q    <= index_i;
      tail_ovr_q <= (|tail_w) && !hit0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      rv_q         <= NegOne;
      ok_q         <= 1'b0;
      cnt_res_q    <= '0;
      drop_q       <= 1'b0;
      count_q      <= '0;
      descending_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        descending_q <= cfg_descending_i;
      end
      // A new result replaces one that is being taken in the same cycle.
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= StUpd;
          end
        end
        StUpd: begin
          if (commit) begin
            state_q     <= StIdle;
            if (kind_q == KindRead) begin
              rv_q      <= rd_ok ? rd_value : NegOne;
              ok_q      <= rd_ok;
              cnt_res_q <= COUNT_W'(count_q);
              drop_q    <= 1'b0;
            end else if (full) begin
              rv_q      <= NegOne;
              ok_q      <= 1'b0;
              cnt_res_q <= COUNT_W'(count_q);
              drop_q    <= 1'b1;
            end else begin
              rv_q      <= NegOne;
              ok_q      <= 1'b0;
              cnt_res_q <= COUNT_W'(count_q + CNT_W'(1));
              drop_q    <= 1'b0;
              count_q   <= count_q + CNT_W'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign read_ok_o    = ok_q;
  assign count_o      = cnt_res_q;
  assign dropped_o    = drop_q;

endmodule

### bench/sipq_checker.sv
`timescale 1ns / 100ps

module sipq_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic            kind_i,
  input  sipq_pkg::data_t value_i,
  input  logic [3:0]      index_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  sipq_pkg::data_t read_value_i,
  input  logic            read_ok_i,
  input  logic [4:0]      count_i,
  input  logic            dropped_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic            cfg_descending_i,
  output int              pending_o,
  output int              failures_o
);
  import sipq_pkg::*;

  typedef struct packed {
    data_t      read_value;
    logic       read_ok;
    logic [4:0] count;
    logic       dropped;
  } queue_result_t;

  // Shadow copy of the sorted store and of the order register.
  data_t         shadow_entries [CAPACITY];
  int            shadow_count = 0;
  logic          shadow_desc = 1'b0;
  queue_result_t awaited_results [$];
  int            mismatch_total = 0;

  assign failures_o = mismatch_total;

  task automatic report_mismatch(string msg);
    $display("[%0t] checker: %s", $time, msg);
    mismatch_total++;
  endtask

  function automatic logic sorts_before(data_t a, data_t b);
    return shadow_desc ? (a >= b) : (a <= b);
  endfunction

  // The front and back are tested first, then the first entry that the new
  // value belongs before; contents are never re-sorted on an order change.
  function automatic int insert_place(data_t v);
    int i;
    if (shadow_count == 0) return 0;
    if (sorts_before(v, shadow_entries[0])) return 0;
    if (sorts_before(shadow_entries[shadow_count-1], v)) return shadow_count;
    for (i = 1; i < shadow_count; i++) begin
      if (sorts_before(v, shadow_entries[i])) return i;
    end
    return shadow_count;
  endfunction

  function automatic queue_result_t predict_queue_result(logic kind, data_t value,
                                                         logic [3:0] index);
    queue_result_t r;
    int place;
    r.read_value = NegOne;
    r.read_ok    = 1'b0;
    r.dropped    = 1'b0;
    if (kind == KindAdd) begin
      if (shadow_count >= CAPACITY) begin
        r.dropped = 1'b1;
      end else begin
        place = insert_place(value);
        for (int j = shadow_count; j > place; j--) begin
          shadow_entries[j] = shadow_entries[j-1];
        end
        shadow_entries[place] = value;
        shadow_count++;
      end
    end else if (int'(index) < shadow_count) begin
      r.read_value = shadow_entries[index];
      r.read_ok    = 1'b1;
    end
    r.count = 5'(shadow_count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      shadow_desc  = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        shadow_desc = cfg_descending_i;
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results = {awaited_results,
                           predict_queue_result(kind_i, value_i, index_i)};
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result with count %0d arrived with no request open",
                                    count_i));
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (read_value_i !== want.read_value)
            report_mismatch($sformatf("read_value is %0d, expected %0d",
                                      read_value_i, want.read_value));
          if (read_ok_i !== want.read_ok)
            report_mismatch($sformatf("read_ok is %b, expected %b", read_ok_i, want.read_ok));
          if (count_i !== want.count)
            report_mismatch($sformatf("count is %0d, expected %0d", count_i, want.count));
          if (dropped_i !== want.dropped)
            report_mismatch($sformatf("dropped is %b, expected %b", dropped_i, want.dropped));
        end
      end
    end
    pending_o <= awaited_results.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sipq_pkg::*;

  localparam int   HalfPeriod    = 6;
  localparam int   ResetCycles   = 3;
  localparam int   RandomPhases  = 6;
  localparam int   PhaseRequests = 250;
  localparam int   IdlePercent   = 19;
  localparam int   HoldOffCycles = 120;
  // A short tail after the last drain is plenty.
  localparam int   DrainCycles   = 16;
  localparam int   CycleLimit    = 200000;
  localparam logic OrderAscending  = 1'b0;
  localparam logic OrderDescending = 1'b1;

  // Every input of the block starts from a known value.
  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_kind     = KindAdd;
  data_t      in_value    = '0;
  logic [3:0] in_index    = '0;
  logic       out_stall   = 1'b0;
  logic       cfg_valid   = 1'b0;
  logic       cfg_desc    = OrderAscending;

  logic       in_stall;
  logic       out_valid;
  data_t      read_value;
  logic       read_ok;
  logic [4:0] count;
  logic       dropped;
  logic       cfg_ready;
  int         pending;
  int         failures;

  // Knobs shared between the request driver and the receiver.
  int send_idle_pct     = IdlePercent;
  int stall_pct         = IdlePercent;
  int hold_off_requests = 0;
  int cycle_count       = 0;

  always begin
    #HalfPeriod clk = 1'b1;
    #HalfPeriod clk = 1'b0;
  end

  sorted_insert_priority_queue dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (in_kind),
    .value_i          (in_value),
    .index_i          (in_index),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .read_value_o     (read_value),
    .read_ok_o        (read_ok),
    .count_o          (count),
    .dropped_o        (dropped),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_descending_i (cfg_desc)
  );

  sipq_checker order_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .kind_i           (in_kind),
    .value_i          (in_value),
    .index_i          (in_index),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .read_value_i     (read_value),
    .read_ok_i        (read_ok),
    .count_i          (count),
    .dropped_i        (dropped),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_descending_i (cfg_desc),
    .pending_o        (pending),
    .failures_o       (failures)
  );

  // A watchdog on the cycle count: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("sorted_insert_priority_queue: mismatch");
      $finish;
    end
  end

  // The receiver stalls at random, and on demand holds off for a long stretch
  // so that the block's output backs up and it has to stall its own input. The
  // hold-off is counted down in this loop, so it does not depend on the driver.
  initial begin : receiver
    int served;
    int hold_left;
    served    = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (served != hold_off_requests) begin
        served    = hold_off_requests;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offers one request and holds it, unchanged, until the block takes it. The
  // valid is only lowered here when an idle gap follows; otherwise the next
  // request goes straight onto the bus in the same step.
  task automatic send_request(logic kind, data_t value, logic [3:0] index);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    in_index <= index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  // Stops offering requests until every result that is owed has come back.
  // The checker's count is registered, hence the first wait.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes the order register; only called while the block is idle.
  task automatic write_order(logic desc);
    cfg_valid <= 1'b1;
    cfg_desc  <= desc;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic       kind;
    data_t      value;
    logic [3:0] index;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Reads of an empty queue come first, at both ends of the
    // index range, and then the extremes of the value range go in.
    write_order(OrderAscending);
    send_request(KindRead, 32'sd0, 4'd0);
    send_request(KindRead, 32'h7fff_ffff, 4'd15);
    send_request(KindAdd, 32'sd0, 4'd15);            // into an empty queue
    send_request(KindAdd, 32'h7fff_ffff, 4'd0);      // lands at the back
    send_request(KindAdd, 32'h8000_0000, 4'd0);      // lands at the front
    send_request(KindAdd, NegOne, 4'd0);             // lands in the middle
    send_request(KindAdd, 32'sd0, 4'd0);             // equal to a stored entry
    send_request(KindRead, 32'sd0, 4'd4);            // the back entry
    send_request(KindRead, 32'sd0, 4'd5);            // just beyond the count
    send_request(KindRead, 32'sd0, 4'd0);

    // The order flips while entries are stored; they are not re-sorted and
    // later adds work on the contents as they stand.
    wait_for_drain();
    write_order(OrderDescending);
    send_request(KindAdd, 32'sd1, 4'd0);
    send_request(KindAdd, 32'h8000_0000, 4'd0);
    send_request(KindRead, 32'sd0, 4'd0);
    send_request(KindRead, 32'sd0, 4'd6);
    send_request(KindRead, 32'sd0, 4'd7);            // beyond the count again

    // Random part, in phases separated by a full drain. The first phase has
    // no idling on either side; the third one has a long receiver hold-off.
    // The queue fills early on, after which adds are dropped as full.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_for_drain();
      write_order((phase % 2 == 0) ? OrderAscending : OrderDescending);
      send_idle_pct = (phase == 0) ? 0 : IdlePercent;
      stall_pct     = (phase == 0) ? 0 : IdlePercent;
      if (phase == 2) hold_off_requests++;
      repeat (PhaseRequests) begin
        kind  = ($urandom_range(99) < 45) ? KindAdd : KindRead;
        index = 4'($urandom_range(15));
        case ($urandom_range(3))
          0: begin
            case ($urandom_range(3))
              0: value = 32'h8000_0000;
              1: value = 32'h7fff_ffff;
              2: value = 32'sd0;
              default: value = NegOne;
            endcase
          end
          // A narrow range gives plenty of equal values.
          1: value = data_t'($urandom_range(8)) - 32'sd4;
          default: value = $urandom;
        endcase
        send_request(kind, value, index);
      end
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("sorted_insert_priority_queue: match");
    end else begin
      $display("sorted_insert_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

### sorted_insert_priority_queue.f
sv/sipq_pkg.sv
sv/sipq_cell.sv
sv/sorted_insert_priority_queue.sv
bench/sipq_checker.sv
bench/testbench.sv
